[design/bba_pkg.sv]
// Package for the buddy block allocator.
// Holds the item structs, status and operation codes, table entry layout and state enum.
// No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

  // Operation codes carried by an input item.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // Block table entry layout: head flag, used flag, order.
  localparam int unsigned ENT_W    = 7;
  localparam int unsigned ENT_HEAD = 6;
  localparam int unsigned ENT_USED = 5;

  typedef struct packed {
    logic        operation;
    logic [15:0] req_bytes;
    logic [15:0] address;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] data_address;
    logic [4:0]  granted_order;
  } bba_out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_SPLIT,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE,
    S_MERGE_CHK,
    S_RESP
  } bba_state_e;

endpackage

[design/buddy_block_allocator.sv]
// Buddy block allocator top level with the block table memory and its sequencer.
// Depends on bba_pkg.
`timescale 1ns / 1ps

// Allocate: the scan walks the heads in address order over the whole pool (up to
// 2^(POOL_ORDER-MIN_ORDER_FLOOR) of them), then splits the chosen block; no fitting block: NO_FIT.
// Free: merges level by level until a buddy does not match or it reaches the whole pool; BAD_FREE
// when the entry is not a used head; a request rejected at decode goes straight to the response. One item is in
// work at a time; the next is accepted in the cycle after a result is produced, even while it waits.
// After reset a clearing pass writes every table entry; min_order resets to 5.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned POOL_ORDER      = 16,
  parameter int unsigned HEADER_BYTES    = 16,
  parameter int unsigned MIN_ORDER_FLOOR = 5
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bba_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bba_out_t out_data_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  localparam int unsigned GW   = POOL_ORDER - MIN_ORDER_FLOOR;
  localparam int unsigned GRAN = 1 << GW;
  localparam logic [4:0] POOL_ORD5  = 5'(POOL_ORDER);
  localparam logic [4:0] FLOOR5     = 5'(MIN_ORDER_FLOOR);

  // Smallest k with 2^k >= v.
  function automatic logic [4:0] ceil_log2(input logic [16:0] v);
    logic [4:0] k;
    k = 5'd17;
    for (int i = 17; i >= 0; i--) begin
      if ((18'd1 << i) >= {1'b0, v}) begin
        k = 5'(i);
      end
    end
    return k;
  endfunction

  // Block table memory.
  logic [ENT_W-1:0] mem [GRAN];
  logic [ENT_W-1:0] rdata_q;
  logic [GW-1:0]    raddr;
  logic             we;
  logic [GW-1:0]    waddr;
  logic [ENT_W-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Control and working registers.
  bba_state_e state_q, state_d;
  logic [4:0]    min_order_q;
  logic [GW:0]   cnt_q, cnt_d;
  logic [GW-1:0] g_q, g_d;
  logic [GW-1:0] bg_q, bg_d;
  logic [GW-1:0] best_g_q, best_g_d;
  logic [4:0]    best_ord_q, best_ord_d;
  logic          found_q, found_d;
  logic [4:0]    need_q, need_d;
  logic [4:0]    ord_q, ord_d;
  bba_out_t      res_q, res_d;
  logic          out_valid_q, out_valid_d;
  bba_out_t      out_q, out_d;

  // Request decode.
  logic [16:0] total;
  logic [4:0]  need_raw, eff_min, need_c;
  logic [15:0] base16;
  logic [31:0] gran_full;
  logic        bad_addr;

  always_comb begin
    total    = {1'b0, in_data_i.req_bytes} + 17'(HEADER_BYTES);
    need_raw = ceil_log2(total);
    if (min_order_q < FLOOR5) begin
      eff_min = FLOOR5;
    end else if (min_order_q > POOL_ORD5) begin
      eff_min = POOL_ORD5;
    end else begin
      eff_min = min_order_q;
    end
    need_c    = (need_raw < eff_min) ? eff_min : need_raw;
    base16    = in_data_i.address - 16'(HEADER_BYTES);
    gran_full = {16'd0, base16} >> MIN_ORDER_FLOOR;
    bad_addr  = ({16'd0, in_data_i.address} < 32'(HEADER_BYTES))
             || (({16'd0, base16} & ((32'd1 << MIN_ORDER_FLOOR) - 32'd1)) != 32'd0)
             || (gran_full >= 32'(GRAN));
  end

  // Entry fields of the word read last cycle.
  logic       e_head, e_used;
  logic [4:0] e_ord;
  logic [GW:0] step;
  logic [GW:0] cnt_nx;
  logic [4:0]  split_ord;
  logic [GW-1:0] buddy;

  always_comb begin
    e_head    = rdata_q[ENT_HEAD];
    e_used    = rdata_q[ENT_USED];
    e_ord     = rdata_q[4:0];
    step      = e_head ? ((GW+1)'(1) << (e_ord - FLOOR5)) : (GW+1)'(1);
    cnt_nx    = cnt_q + step;
    split_ord = ord_q - 5'd1;
    buddy     = g_q ^ GW'((GW+1)'(1) << (ord_q - FLOOR5));
  end

  // Next state, memory access and results.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    g_d         = g_q;
    bg_d        = bg_q;
    best_g_d    = best_g_q;
    best_ord_d  = best_ord_q;
    found_d     = found_q;
    need_d      = need_q;
    ord_d       = ord_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    raddr       = cnt_q[GW-1:0];
    we          = 1'b0;
    waddr       = g_q;
    wdata       = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q[GW-1:0];
        wdata = (cnt_q == '0) ? ENT_W'({1'b1, 1'b0, POOL_ORD5}) : '0;
        cnt_d = cnt_q + (GW+1)'(1);
        if (cnt_q == (GW+1)'(GRAN - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d = '0;
          if (in_data_i.operation == OP_ALLOC) begin
            need_d  = need_c;
            cnt_d   = '0;
            found_d = 1'b0;
            if (need_c > POOL_ORD5) begin
              res_d.status = ST_NO_FIT;
              state_d      = S_RESP;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            g_d = gran_full[GW-1:0];
            if (bad_addr) begin
              res_d.status = ST_BAD_FREE;
              state_d      = S_RESP;
            end else begin
              state_d = S_FREE_RD;
            end
          end
        end
      end
      S_SCAN: begin
        raddr   = cnt_q[GW-1:0];
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (e_head && !e_used && e_ord >= need_q && (!found_q || e_ord < best_ord_q)) begin
          found_d    = 1'b1;
          best_ord_d = e_ord;
          best_g_d   = cnt_q[GW-1:0];
        end
        cnt_d = cnt_nx;
        if (cnt_nx[GW]) begin
          ord_d = (e_head && !e_used && e_ord >= need_q && (!found_q || e_ord < best_ord_q))
                  ? e_ord : best_ord_q;
          if (found_q || (e_head && !e_used && e_ord >= need_q)) begin
            state_d = S_SPLIT;
          end else begin
            res_d.status = ST_NO_FIT;
            state_d      = S_RESP;
          end
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        if (ord_q > need_q) begin
          waddr = best_g_q + GW'((GW+1)'(1) << (split_ord - FLOOR5));
          wdata = ENT_W'({1'b1, 1'b0, split_ord});
          ord_d = split_ord;
        end else begin
          waddr = best_g_q;
          wdata = ENT_W'({1'b1, 1'b1, ord_q});
          res_d.status        = ST_OK;
          res_d.data_address  =
            16'((32'(best_g_q) << MIN_ORDER_FLOOR) + 32'(HEADER_BYTES));
          res_d.granted_order = ord_q;
          state_d = S_RESP;
        end
      end
      S_FREE_RD: begin
        raddr   = g_q;
        state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (!e_head || !e_used) begin
          res_d.status = ST_BAD_FREE;
          state_d      = S_RESP;
        end else begin
          ord_d   = e_ord;
          state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        raddr = buddy;
        bg_d  = buddy;
        if (ord_q < POOL_ORD5 && ord_q >= FLOOR5) begin
          state_d = S_MERGE_CHK;
        end else begin
          we    = 1'b1;
          waddr = g_q;
          wdata = ENT_W'({1'b1, 1'b0, ord_q});
          res_d.status        = ST_OK;
          res_d.granted_order = ord_q;
          state_d = S_RESP;
        end
      end
      S_MERGE_CHK: begin
        we = 1'b1;
        if (!e_head || e_used || e_ord != ord_q) begin
          waddr = g_q;
          wdata = ENT_W'({1'b1, 1'b0, ord_q});
          res_d.status        = ST_OK;
          res_d.granted_order = ord_q;
          state_d = S_RESP;
        end else begin
          waddr   = (bg_q < g_q) ? g_q : bg_q;
          wdata   = '0;
          g_d     = (bg_q < g_q) ? bg_q : g_q;
          ord_d   = ord_q + 5'd1;
          state_d = S_MERGE;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      min_order_q <= 5'd5;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        min_order_q <= cfg_data_i;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    g_q        <= g_d;
    bg_q       <= bg_d;
    best_g_q   <= best_g_d;
    best_ord_q <= best_ord_d;
    found_q    <= found_d;
    need_q     <= need_d;
    ord_q      <= ord_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[bench/tb_buddy_block_allocator.sv]
// Testbench for the buddy block allocator: directed and random allocate/free traffic
// checked against an in-bench model of the block table. Depends on bba_pkg and the RTL.
`timescale 1ns / 1ps

module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int unsigned POOL   = 16;
  localparam int unsigned HDR    = 16;
  localparam int unsigned FLOOR  = 5;
  localparam int unsigned GRANS  = 1 << (POOL - FLOOR);
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam logic [4:0] ORD_MASK = 5'h1f;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  bba_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  bba_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [4:0] cfg_data_i = '0;

  // Model of the allocator state.
  logic [6:0]  blk_tab [GRANS];
  logic [4:0]  min_ord_reg;
  bba_out_t    expected_q [$];
  logic [15:0] live_q [$];
  logic [15:0] last_freed;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  buddy_block_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Allocate: lowest-address free block of the smallest fitting order, split down.
  function automatic bba_out_t alloc_block(logic [15:0] req);
    bba_out_t    r;
    int unsigned total, need, mn, best_ord, best_g, ord;
    r = '0;
    total = req + HDR;
    need = 0;
    while (need < 31 && (1 << need) < total) need++;
    mn = (min_ord_reg < FLOOR) ? FLOOR : (min_ord_reg > POOL) ? POOL : min_ord_reg;
    if (need < mn) need = mn;
    r.status = ST_NO_FIT;
    if (need > POOL) return r;
    best_ord = 255;
    best_g = 0;
    for (int g = 0; g < GRANS; g++) begin
      if (blk_tab[g][ENT_HEAD] && !blk_tab[g][ENT_USED]) begin
        ord = 32'(blk_tab[g] & ORD_MASK);
        if (ord >= need && ord < best_ord) begin
          best_ord = ord;
          best_g = g;
        end
      end
    end
    if (best_ord == 255) return r;
    ord = best_ord;
    while (ord > need) begin
      ord--;
      blk_tab[(best_g + (1 << (ord - FLOOR))) % GRANS] = 7'(32'h40 | ord);
    end
    blk_tab[best_g] = 7'(32'h60 | ord);
    r.status = ST_OK;
    r.data_address = 16'((best_g << FLOOR) + HDR);
    r.granted_order = ord[4:0];
    return r;
  endfunction

  // Free: release a used head and merge with free buddies of equal order.
  function automatic bba_out_t free_block(logic [15:0] addr);
    bba_out_t    r;
    int unsigned base, g, bg, ord;
    logic [6:0]  e;
    r = '0;
    r.status = ST_BAD_FREE;
    if (addr < HDR) return r;
    base = addr - HDR;
    if (base % (1 << FLOOR) != 0) return r;
    g = base >> FLOOR;
    if (g >= GRANS) return r;
    e = blk_tab[g];
    if (!e[ENT_HEAD] || !e[ENT_USED]) return r;
    ord = 32'(e & ORD_MASK);
    while (ord < POOL && ord >= FLOOR) begin
      bg = (g ^ (1 << (ord - FLOOR))) % GRANS;
      e = blk_tab[bg];
      if (!e[ENT_HEAD] || e[ENT_USED] || 32'(e & ORD_MASK) != ord) break;
      if (bg < g) begin
        blk_tab[g] = '0;
        g = bg;
      end else begin
        blk_tab[bg] = '0;
      end
      ord++;
    end
    blk_tab[g] = 7'(32'h40 | ord);
    r.status = ST_OK;
    r.granted_order = ord[4:0];
    return r;
  endfunction

  // Offer one item; it is predicted at the edge that accepts it. Valid stays high on return.
  task automatic send_item(logic op, logic [15:0] req, logic [15:0] addr);
    bba_out_t r;
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 24) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = '{operation: op, req_bytes: req, address: addr};
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_FREE) begin
      r = free_block(addr);
      if (r.status == ST_OK) begin
        last_freed = addr;
        foreach (live_q[i]) if (live_q[i] == addr) begin
          live_q.delete(i);
          break;
        end
      end
    end else begin
      r = alloc_block(req);
      if (r.status == ST_OK) live_q.push_back(r.data_address);
    end
    expected_q.push_back(r);
  endtask

  // Let the block go idle, then write min_order.
  task automatic write_min_order(logic [4:0] v);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    min_ord_reg = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic release_all();
    while (live_q.size() != 0) send_item(OP_FREE, 16'($urandom), live_q[0]);
  endtask

  // Size extremes, the too-large request, zero bytes and every kind of bad free.
  task automatic test_directed();
    send_item(OP_ALLOC, 16'd65520, 16'hffff);
    send_item(OP_ALLOC, 16'd0, 16'h0000);
    send_item(OP_FREE, 16'hffff, 16'd16);
    send_item(OP_FREE, 16'h0000, 16'd16);
    send_item(OP_ALLOC, 16'd65535, 16'h0);
    send_item(OP_ALLOC, 16'd65521, 16'h0);
    send_item(OP_ALLOC, 16'd0, 16'h0);
    send_item(OP_ALLOC, 16'd16, 16'h0);
    send_item(OP_ALLOC, 16'd17, 16'h0);
    send_item(OP_ALLOC, 16'd1000, 16'h0);
    send_item(OP_FREE, 16'd0, 16'd15);
    send_item(OP_FREE, 16'd0, 16'd0);
    send_item(OP_FREE, 16'd0, 16'd17);
    send_item(OP_FREE, 16'd0, 16'd65535);
    send_item(OP_FREE, 16'd0, 16'd65520);
    send_item(OP_FREE, 16'd0, 16'd4112);
    send_item(OP_ALLOC, 16'd32752, 16'h0);
    send_item(OP_ALLOC, 16'd32752, 16'h0);
    release_all();
    send_item(OP_FREE, 16'd0, last_freed);
  endtask

  // Mostly well-formed alloc/free traffic, with bad frees and odd sizes mixed in.
  task automatic test_random(int unsigned n);
    int unsigned r, k;
    logic [15:0] req;
    for (int i = 0; i < n; i++) begin
      quiet = (i >= n / 3 && i < n / 2);
      r = $urandom_range(0, 99);
      if (live_q.size() > 24 || (r < 40 && live_q.size() != 0)) begin
        k = $urandom_range(0, live_q.size() - 1);
        send_item(OP_FREE, 16'($urandom), live_q[k]);
      end else if (r < 48) begin
        send_item(OP_FREE, 16'($urandom), (r & 1) ? last_freed : 16'($urandom));
      end else begin
        k = $urandom_range(0, 99);
        req = (k < 70) ? 16'($urandom_range(0, 200)) :
              (k < 90) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
        send_item(OP_ALLOC, req, 16'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  // The receiver stalls for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_item(OP_ALLOC, 16'($urandom_range(0, 100)), 16'h0);
    release_all();
  endtask

  // Receiver: random stalls, a stall-free stretch, and a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req) begin
      out_ready_i <= 1'b0;
      hold_req = 1'b0;
      repeat (400) @(negedge clk_i);
    end else begin
      out_ready_i <= quiet || ($urandom_range(0, 99) >= 24);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    bba_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        e = expected_q.pop_front();
        if (out_data_o.status !== e.status || out_data_o.data_address !== e.data_address ||
            out_data_o.granted_order !== e.granted_order) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d addr %0d order %0d, got %0d %0d %0d",
                     e.status, e.data_address, e.granted_order, out_data_o.status,
                     out_data_o.data_address, out_data_o.granted_order);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake on the input, output or config port.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int g = 0; g < GRANS; g++) blk_tab[g] = '0;
    blk_tab[0] = 7'(32'h40 | POOL);
    min_ord_reg = 5'd5;
    last_freed = 16'd16;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    test_random(300);
    write_min_order(5'd16);
    test_random(40);
    release_all();
    write_min_order(5'd31);
    test_random(30);
    release_all();
    write_min_order(5'd0);
    test_random(300);
    write_min_order(5'd9);
    test_random(250);
    write_min_order(5'($urandom_range(5, 12)));
    test_random(200);
    release_all();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
design/bba_pkg.sv
design/buddy_block_allocator.sv
bench/tb_buddy_block_allocator.sv
